// File: src/sliding_window_mode_tracker_core_macros.svh
// ----------------------------------------------------------------------------
// Mode tracker assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MODE_TRACKER_CORE_MACROS_SVH
`define SLIDING_WINDOW_MODE_TRACKER_CORE_MACROS_SVH

// same-cycle implication
`define SWMT_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("mode tracker check failed");

// next-cycle implication
`define SWMT_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("mode tracker check failed");

`endif

// File: src/swmt_pkg.sv
// ----------------------------------------------------------------------------
// Mode tracker package
// Item kinds, controller states and scan status shared by the core modules.
// ----------------------------------------------------------------------------
package swmt_pkg;

    localparam int COUNT_BITS = 32;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_INIT = 4'b0001,
        ST_IDLE = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_UPD  = 4'b1000
    } state_t;

    typedef struct packed {
        logic match;
        logic free;
        logic best;
    } scan_status_t;

endpackage

// File: src/swmt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module swmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/swmt_scan.sv
// ----------------------------------------------------------------------------
// Mode tracker table scan
// Walks entries as they come out of the RAM: first key match, lowest free
// slot and best candidate for the mode.
// ----------------------------------------------------------------------------
module swmt_scan #(
    parameter int AW       = 6,
    parameter int KEY_BITS = 32,
    parameter int ROW_BITS = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         clear,
    input  logic                         vld,
    input  logic [AW-1:0]                idx,
    input  logic [KEY_BITS-1:0]          ent_key,
    input  logic [swmt_pkg::COUNT_BITS-1:0] ent_count,
    input  logic [ROW_BITS-1:0]          ent_row,
    input  logic [KEY_BITS-1:0]          key,
    output swmt_pkg::scan_status_t       status,
    output logic [AW-1:0]                match_idx,
    output logic [swmt_pkg::COUNT_BITS-1:0] match_count,
    output logic [ROW_BITS-1:0]          match_row,
    output logic [AW-1:0]                free_idx,
    output logic [KEY_BITS-1:0]          best_key,
    output logic [swmt_pkg::COUNT_BITS-1:0] best_count
);
    import swmt_pkg::*;

    scan_status_t            status_reg;
    logic [AW-1:0]           match_idx_reg;
    logic [COUNT_BITS-1:0]   match_count_reg;
    logic [ROW_BITS-1:0]     match_row_reg;
    logic [AW-1:0]           free_idx_reg;
    logic [KEY_BITS-1:0]     best_key_reg;
    logic [COUNT_BITS-1:0]   best_count_reg;
    logic [ROW_BITS-1:0]     best_row_reg;
    logic                    in_use;
    logic                    better;

    assign in_use = (ent_count != '0);
    // ties go to the earlier first row, then to the lower slot
    assign better = in_use && (!status_reg.best || (ent_count > best_count_reg) ||
                    ((ent_count == best_count_reg) && (ent_row < best_row_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg      <= '0;
            match_idx_reg   <= '0;
            match_count_reg <= '0;
            match_row_reg   <= '0;
            free_idx_reg    <= '0;
            best_key_reg    <= '0;
            best_count_reg  <= '0;
            best_row_reg    <= '0;
        end
        else if (clear)
        begin
            status_reg <= '0;
        end
        else if (vld)
        begin
            if (!status_reg.match && in_use && (ent_key == key))
            begin
                status_reg.match <= 1'b1;
                match_idx_reg    <= idx;
                match_count_reg  <= ent_count;
                match_row_reg    <= ent_row;
            end
            if (!status_reg.free && !in_use)
            begin
                status_reg.free <= 1'b1;
                free_idx_reg    <= idx;
            end
            if (better)
            begin
                status_reg.best <= 1'b1;
                best_key_reg    <= ent_key;
                best_count_reg  <= ent_count;
                best_row_reg    <= ent_row;
            end
        end
    end

    assign status      = status_reg;
    assign match_idx   = match_idx_reg;
    assign match_count = match_count_reg;
    assign match_row   = match_row_reg;
    assign free_idx    = free_idx_reg;
    assign best_key    = best_key_reg;
    assign best_count  = best_count_reg;

endmodule

// File: src/sliding_window_mode_tracker_core.sv
// Add and remove keep busy high from accept through a full scan and the table update.
// Query with a current mode: result in the cycle after accept; with a stale mode, after a full scan.
// Clear: every RAM entry zeroed, one RAM entry written per cycle; throughput set by the RAM scan.
// Reset: asynchronous, active low; then a clearing pass over every entry with busy high.
// Results are a one-cycle strobe on done; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Sliding window mode tracker core
// Key frequency table in one RAM, scanned per add, remove and stale-mode query, with a tracked mode.
// ----------------------------------------------------------------------------
module sliding_window_mode_tracker_core #(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 32,
    parameter int ROW_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [31:0] row,
    output logic        done,
    output logic [31:0] mode_key,
    output logic [31:0] mode_count,
    output logic        found,
    output logic        overflow
);
    import swmt_pkg::*;

    localparam int AW = $clog2(ENTRIES > 1 ? ENTRIES : 2);
    localparam int W  = KEY_BITS + COUNT_BITS + ROW_BITS;
    localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
    localparam logic [AW:0]   DEPTH_CNT = (AW + 1)'(ENTRIES);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    state_t                  state_reg, state_next;
    logic [AW:0]             addr_reg, addr_next;
    logic                    rd_vld_reg, rd_vld_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    kind_t                   kind_reg, kind_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [ROW_BITS-1:0]     row_reg, row_next;
    logic [KEY_BITS-1:0]     mkey_reg, mkey_next;
    logic [COUNT_BITS-1:0]   mcount_reg, mcount_next;
    logic                    mvalid_reg, mvalid_next;
    logic                    ovf_reg, ovf_next;
    logic                    done_reg, done_next;
    logic [31:0]             okey_reg, okey_next;
    logic [31:0]             ocount_reg, ocount_next;
    logic                    ofound_reg, ofound_next;
    logic                    oovf_reg, oovf_next;

    logic                    we, re, scan_clear;
    logic [AW-1:0]           waddr, raddr;
    logic [W-1:0]            wdata, rdata;
    logic [COUNT_BITS-1:0]   inc_count;
    logic [ROW_BITS-1:0]     new_row;

    scan_status_t            st;
    logic [AW-1:0]           match_idx, free_idx;
    logic [COUNT_BITS-1:0]   match_count, best_count;
    logic [ROW_BITS-1:0]     match_row;
    logic [KEY_BITS-1:0]     best_key;

    swmt_ram #(.WIDTH(W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    swmt_scan #(.AW(AW), .KEY_BITS(KEY_BITS), .ROW_BITS(ROW_BITS)) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (scan_clear),
        .vld         (rd_vld_reg),
        .idx         (rd_idx_reg),
        .ent_key     (rdata[W-1 -: KEY_BITS]),
        .ent_count   (rdata[ROW_BITS +: COUNT_BITS]),
        .ent_row     (rdata[ROW_BITS-1:0]),
        .key         (key_reg),
        .status      (st),
        .match_idx   (match_idx),
        .match_count (match_count),
        .match_row   (match_row),
        .free_idx    (free_idx),
        .best_key    (best_key),
        .best_count  (best_count)
    );

    always_comb
    begin
        state_next  = state_reg;
        addr_next   = addr_reg;
        rd_vld_next = 1'b0;
        rd_idx_next = addr_reg[AW-1:0];
        kind_next   = kind_reg;
        key_next    = key_reg;
        row_next    = row_reg;
        mkey_next   = mkey_reg;
        mcount_next = mcount_reg;
        mvalid_next = mvalid_reg;
        ovf_next    = ovf_reg;
        done_next   = 1'b0;
        okey_next   = okey_reg;
        ocount_next = ocount_reg;
        ofound_next = ofound_reg;
        oovf_next   = oovf_reg;
        we          = 1'b0;
        waddr       = addr_reg[AW-1:0];
        wdata       = '0;
        re          = 1'b0;
        raddr       = addr_reg[AW-1:0];
        scan_clear  = 1'b0;
        inc_count   = (match_count == COUNT_MAX) ? match_count : match_count + 1'b1;
        new_row     = (row_reg < match_row) ? row_reg : match_row;

        case (state_reg)
            ST_INIT:
            begin
                we = 1'b1;
                if (addr_reg[AW-1:0] == LAST)
                begin
                    state_next = ST_IDLE;
                    addr_next  = '0;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind_t'(kind);
                    key_next  = KEY_BITS'(key);
                    row_next  = ROW_BITS'(row);
                    addr_next = '0;
                    case (kind_t'(kind))
                        KIND_CLEAR:
                        begin
                            state_next  = ST_INIT;
                            mkey_next   = '0;
                            mcount_next = '0;
                            mvalid_next = 1'b0;
                            ovf_next    = 1'b0;
                        end
                        KIND_QUERY:
                        begin
                            if (mvalid_reg)
                            begin
                                done_next   = 1'b1;
                                okey_next   = 32'(mkey_reg);
                                ocount_next = mcount_reg;
                                ofound_next = 1'b1;
                                oovf_next   = ovf_reg;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                                scan_clear = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = ST_SCAN;
                            scan_clear = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (addr_reg < DEPTH_CNT)
                begin
                    re          = 1'b1;
                    rd_vld_next = 1'b1;
                    addr_next   = addr_reg + 1'b1;
                end
                if (rd_vld_reg && (rd_idx_reg == LAST))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                state_next = ST_IDLE;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (st.match)
                        begin
                            we    = 1'b1;
                            waddr = match_idx;
                            wdata = {key_reg, inc_count, new_row};
                            if (inc_count > mcount_reg)
                            begin
                                mvalid_next = 1'b1;
                                mcount_next = inc_count;
                                mkey_next   = key_reg;
                            end
                        end
                        else if (st.free)
                        begin
                            we    = 1'b1;
                            waddr = free_idx;
                            wdata = {key_reg, COUNT_BITS'(1), row_reg};
                            if (mcount_reg == '0)
                            begin
                                mvalid_next = 1'b1;
                                mcount_next = COUNT_BITS'(1);
                                mkey_next   = key_reg;
                            end
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (st.match)
                        begin
                            we    = 1'b1;
                            waddr = match_idx;
                            wdata = {key_reg, match_count - 1'b1, match_row};
                            if ((mcount_reg == match_count) && (mkey_reg == key_reg))
                            begin
                                mvalid_next = 1'b0;
                            end
                        end
                    end
                    KIND_QUERY:
                    begin
                        done_next = 1'b1;
                        oovf_next = ovf_reg;
                        if (st.best)
                        begin
                            mkey_next   = best_key;
                            mcount_next = best_count;
                            mvalid_next = 1'b1;
                            okey_next   = 32'(best_key);
                            ocount_next = best_count;
                            ofound_next = 1'b1;
                        end
                        else
                        begin
                            mcount_next = '0;
                            mvalid_next = 1'b0;
                            okey_next   = '0;
                            ocount_next = '0;
                            ofound_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
            mvalid_reg <= 1'b0;
            mkey_reg   <= '0;
            mcount_reg <= '0;
            ovf_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            rd_vld_reg <= rd_vld_next;
            mvalid_reg <= mvalid_next;
            mkey_reg   <= mkey_next;
            mcount_reg <= mcount_next;
            ovf_reg    <= ovf_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        row_reg    <= row_next;
        okey_reg   <= okey_next;
        ocount_reg <= ocount_next;
        ofound_reg <= ofound_next;
        oovf_reg   <= oovf_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign mode_key   = okey_reg;
    assign mode_count = ocount_reg;
    assign found      = ofound_reg;
    assign overflow   = oovf_reg;

endmodule

// File: src/swmt_checker.sv
// ----------------------------------------------------------------------------
// Mode tracker port checker
// Checks result and busy behavior as seen on the core's ports.
// ----------------------------------------------------------------------------
`include "sliding_window_mode_tracker_core_macros.svh"

module swmt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] mode_key,
    input logic [31:0] mode_count,
    input logic        found
);

    // an accepted item either keeps the core busy or answers at once
    `SWMT_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || done)
    // a null result carries zeros
    `SWMT_ASSERT_NOW(a_null_zero, clk, rst_n, done && !found, (mode_key | mode_count) == 32'd0)
    // a found mode has at least one occurrence
    `SWMT_ASSERT_NOW(a_found_count, clk, rst_n, done && found, mode_count != 32'd0)

endmodule

bind sliding_window_mode_tracker_core swmt_checker u_swmt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .mode_key   (mode_key),
    .mode_count (mode_count),
    .found      (found)
);
